/* rtl/ddaq_pkg.sv */
// Shared constants, types and codes for the dust density air quality scorer.
`default_nettype none
package ddaq_pkg;

   // sizes
   localparam int ADC_BITS    = 10;
   localparam int WINDOW_WRAP = 101;
   localparam int CNT_W       = $clog2(WINDOW_WRAP);
   localparam int SAMPLE_W    = 10;
   localparam int REG_W       = 10;
   localparam int CSR_IDX_W   = 8;
   localparam int DENS_W      = 7;
   localparam int DIGIT_W     = 4;
   localparam int CLASS_W     = 2;
   localparam int SUM_W       = 11;
   localparam int SCORE_W     = 4;
   localparam int WCOUNT_W    = 16;
   localparam int DIV_W       = 32;
   localparam int DEN_W       = WCOUNT_W + 1;
   localparam int DIV_CNT_W   = $clog2(DIV_W);
   localparam int PROD_W      = ADC_BITS + 8;

   // density conversion: (85*adc - 10*2^ADC_BITS) >> ADC_BITS, limited to 99
   localparam int DENS_SCALE  = 85;
   localparam int DENS_OFFSET = 10;
   localparam int DENS_MAX    = 99;

   // window quotient: sum / (WINDOW_WRAP-1) by a rounded-up reciprocal,
   // exact for every sum that fits in SUM_W bits
   localparam int WIN_DIVISOR     = WINDOW_WRAP - 1;
   localparam int WIN_RECIP_SHIFT = SUM_W + 10;
   localparam int WIN_RECIP       = ((1 << WIN_RECIP_SHIFT) + WIN_DIVISOR - 1) / WIN_DIVISOR;
   localparam int WIN_PROD_W      = SUM_W + WIN_RECIP_SHIFT + 1;

   // band scores
   localparam logic [SCORE_W-1:0] SCORE_BAND_ZERO  = SCORE_W'(0);
   localparam logic [SCORE_W-1:0] SCORE_BAND_ONE   = SCORE_W'(1);
   localparam logic [SCORE_W-1:0] SCORE_BAND_TWO   = SCORE_W'(5);
   localparam logic [SCORE_W-1:0] SCORE_BAND_THREE = SCORE_W'(10);

   // quality classes
   localparam logic [CLASS_W-1:0] CLASS_EXCELLENT = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_GOOD      = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_POOR      = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_WORSE     = 2'd3;

   // final average limits
   localparam int FINAL_GOOD_LIMIT = 2;
   localparam int FINAL_POOR_LIMIT = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_CUTOFF      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_ONE_LIMIT   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_TWO_LIMIT   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_THREE_LIMIT = CSR_IDX_W'(3);

   // register reset values
   localparam logic [REG_W-1:0] RST_ZERO_CUTOFF      = REG_W'(120);
   localparam logic [REG_W-1:0] RST_BAND_ONE_LIMIT   = REG_W'(168);
   localparam logic [REG_W-1:0] RST_BAND_TWO_LIMIT   = REG_W'(216);
   localparam logic [REG_W-1:0] RST_BAND_THREE_LIMIT = REG_W'(313);

   // action codes
   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_FINISH = 1'b1;

   typedef struct packed {
      logic [REG_W-1:0] zero_cutoff;
      logic [REG_W-1:0] band_one_limit;
      logic [REG_W-1:0] band_two_limit;
      logic [REG_W-1:0] band_three_limit;
   } ddaq_cfg_type;

   typedef struct packed {
      logic [DENS_W-1:0]  density;
      logic [DIGIT_W-1:0] tenths;
      logic [DIGIT_W-1:0] hundredths;
      logic [SCORE_W-1:0] score;
   } ddaq_conv_type;

   typedef struct packed {
      logic start;
      logic [DIV_W-1:0] dividend;
      logic [DEN_W-1:0] divisor;
   } ddaq_div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } ddaq_div_stat_type;

   typedef struct packed {
      logic [DENS_W-1:0]  density_hundredths;
      logic [DIGIT_W-1:0] tenths_digit;
      logic [DIGIT_W-1:0] hundredths_digit;
      logic               window_done;
      logic [CLASS_W-1:0] window_class;
      logic               is_final;
      logic [CLASS_W-1:0] final_class;
      logic [DIV_W-1:0]   final_average;
   } ddaq_res_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WIN_DIV,
      ST_FIN_DIV,
      ST_OUT
   } ddaq_state_type;

endpackage
`default_nettype wire

/* rtl/ddaq_req_if.sv */
// Input channel: ADC sample or finish event.
`default_nettype none
interface ddaq_req_if;
   import ddaq_pkg::*;
   logic                valid;
   logic                ready;
   logic                action;
   logic [SAMPLE_W-1:0] sample;
   modport source (output valid, action, sample, input ready);
   modport sink   (input valid, action, sample, output ready);
endinterface
`default_nettype wire

/* rtl/ddaq_rsp_if.sv */
// Result channel: density, digits, window and final classification.
`default_nettype none
interface ddaq_rsp_if;
   import ddaq_pkg::*;
   logic               valid;
   logic               ready;
   logic [DENS_W-1:0]  density_hundredths;
   logic [DIGIT_W-1:0] tenths_digit;
   logic [DIGIT_W-1:0] hundredths_digit;
   logic               window_done;
   logic [CLASS_W-1:0] window_class;
   logic               is_final;
   logic [CLASS_W-1:0] final_class;
   logic [DIV_W-1:0]   final_average;
   modport source (output valid, density_hundredths, tenths_digit, hundredths_digit,
                   window_done, window_class, is_final, final_class, final_average,
                   input ready);
   modport sink   (input valid, density_hundredths, tenths_digit, hundredths_digit,
                   window_done, window_class, is_final, final_class, final_average,
                   output ready);
endinterface
`default_nettype wire

/* rtl/ddaq_csr_if.sv */
// Configuration write channel: register index and data.
`default_nettype none
interface ddaq_csr_if;
   import ddaq_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [REG_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/dust_density_air_quality_scorer_top.sv */
// Top level of the dust density air quality scorer: sequencer, run state, result register.
`default_nettype none
//
//  channel  dir  handshake     payload
//  req_ch   in   valid/ready   action, sample
//  rsp_ch   out  valid/ready   density_hundredths, tenths_digit, hundredths_digit,
//                              window_done, window_class, is_final, final_class,
//                              final_average
//  csr_ch   in   valid/ready   index, data (always ready)
//
//  A plain sample goes through the pending register into the result register; a window-closing
//  sample first passes ST_WIN_DIV (one reciprocal multiply for the quotient); the next
//  transaction is taken back in idle. The finish event runs the 32-step divider, one
//  quotient bit per cycle, and its result goes via the pending register to the output.
//  Reset is synchronous and active high; it restores register defaults and clears the run.
//  req_ch is ready only in idle; a finished result waits in a pending register while the
//  output register is stalled, and the next transaction is taken once it moves out.
//  After the finish event, transactions are taken and dropped without a result.
//
module dust_density_air_quality_scorer_top (
   input  wire logic clock,
   input  wire logic reset,
   ddaq_req_if.sink  req_ch,
   ddaq_rsp_if.source rsp_ch,
   ddaq_csr_if.sink  csr_ch
);
   import ddaq_pkg::*;

   ddaq_cfg_type      cfg;
   ddaq_conv_type     conv;
   ddaq_div_req_type  div_req;
   ddaq_div_stat_type div_stat;
   logic [DIV_W-1:0]  div_quo;

   ddaq_state_type       st_ff, st_in;
   logic                 finished_ff, finished_in;
   logic [CNT_W-1:0]     sample_count_ff, sample_count_in;
   logic [SUM_W-1:0]     window_sum_ff, window_sum_in;
   logic [DIV_W-1:0]     run_total_ff, run_total_in;
   logic [WCOUNT_W-1:0]  window_count_ff, window_count_in;
   ddaq_res_type         pend_ff, pend_in;
   ddaq_res_type         out_ff, out_in;
   logic                 out_valid_ff, out_valid_in;

   logic                 accept;
   logic                 out_free;
   logic [CNT_W-1:0]     count_next;
   logic [SUM_W-1:0]     sum_next;
   logic [WIN_PROD_W-1:0] win_prod;
   logic [SUM_W:0]       win_quo;

   ddaq_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   ddaq_conv u_conv (
      .sample (req_ch.sample),
      .cfg    (cfg),
      .conv   (conv)
   );

   ddaq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   assign req_ch.ready = (st_ff == ST_IDLE);
   assign accept       = req_ch.valid & req_ch.ready;
   assign out_free     = ~out_valid_ff | rsp_ch.ready;

   // result register drives the channel
   assign rsp_ch.valid              = out_valid_ff;
   assign rsp_ch.density_hundredths = out_ff.density_hundredths;
   assign rsp_ch.tenths_digit       = out_ff.tenths_digit;
   assign rsp_ch.hundredths_digit   = out_ff.hundredths_digit;
   assign rsp_ch.window_done        = out_ff.window_done;
   assign rsp_ch.window_class       = out_ff.window_class;
   assign rsp_ch.is_final           = out_ff.is_final;
   assign rsp_ch.final_class        = out_ff.final_class;
   assign rsp_ch.final_average      = out_ff.final_average;

   always_comb begin
      st_in           = st_ff;
      finished_in     = finished_ff;
      sample_count_in = sample_count_ff;
      window_sum_in   = window_sum_ff;
      run_total_in    = run_total_ff;
      window_count_in = window_count_ff;
      pend_in         = pend_ff;
      out_in          = out_ff;
      out_valid_in    = out_valid_ff & ~rsp_ch.ready;
      div_req.start    = 1'b0;
      div_req.dividend = run_total_ff;
      div_req.divisor  = DEN_W'(window_count_ff) + 1'b1;

      // window position wraps after the last slot
      count_next = (sample_count_ff == CNT_W'(WINDOW_WRAP - 1)) ? '0
                   : sample_count_ff + 1'b1;
      sum_next   = window_sum_ff + SUM_W'(conv.score);

      // window quotient from the registered sum by reciprocal multiply
      win_prod = WIN_PROD_W'(window_sum_ff) * WIN_PROD_W'(WIN_RECIP);
      win_quo  = win_prod[WIN_PROD_W-1:WIN_RECIP_SHIFT];

      unique case (st_ff)
         ST_IDLE: begin
            if (accept && !finished_ff) begin
               pend_in = '0;
               if (req_ch.action == ACT_FINISH) begin
                  div_req.start    = 1'b1;
                  pend_in.is_final = 1'b1;
                  st_in            = ST_FIN_DIV;
               end else begin
                  pend_in.density_hundredths = conv.density;
                  pend_in.tenths_digit       = conv.tenths;
                  pend_in.hundredths_digit   = conv.hundredths;
                  sample_count_in            = count_next;
                  window_sum_in              = sum_next;
                  if (count_next == CNT_W'(WINDOW_WRAP - 1)) begin
                     // close the window: hold the sum for the quotient
                     pend_in.window_done = 1'b1;
                     window_count_in     = window_count_ff + 1'b1;
                     st_in               = ST_WIN_DIV;
                  end else begin
                     st_in = ST_OUT;
                  end
               end
            end
         end
         ST_WIN_DIV: begin
            // add the full quotient to the run, restart the sum
            run_total_in         = run_total_ff + DIV_W'(win_quo);
            pend_in.window_class = (win_quo > (SUM_W+1)'(CLASS_WORSE)) ? CLASS_WORSE
                                   : CLASS_W'(win_quo);
            window_sum_in        = '0;
            st_in                = ST_OUT;
         end
         ST_FIN_DIV: begin
            if (div_stat.done) begin
               run_total_in          = div_quo;
               finished_in           = 1'b1;
               pend_in.final_average = div_quo;
               if (div_quo == '0) begin
                  pend_in.final_class = CLASS_EXCELLENT;
               end else if (div_quo <= DIV_W'(FINAL_GOOD_LIMIT)) begin
                  pend_in.final_class = CLASS_GOOD;
               end else if (div_quo <= DIV_W'(FINAL_POOR_LIMIT)) begin
                  pend_in.final_class = CLASS_POOR;
               end else begin
                  pend_in.final_class = CLASS_WORSE;
               end
               st_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold the result until the output register frees up
            if (out_free) begin
               out_in       = pend_ff;
               out_valid_in = 1'b1;
               st_in        = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff           <= ST_IDLE;
         finished_ff     <= 1'b0;
         sample_count_ff <= '0;
         window_sum_ff   <= '0;
         run_total_ff    <= '0;
         window_count_ff <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         st_ff           <= st_in;
         finished_ff     <= finished_in;
         sample_count_ff <= sample_count_in;
         window_sum_ff   <= window_sum_in;
         run_total_ff    <= run_total_in;
         window_count_ff <= window_count_in;
         out_valid_ff    <= out_valid_in;
      end
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end
endmodule
`default_nettype wire

/* rtl/ddaq_csr.sv */
// Configuration register file for the band limits and zero cutoff.
`default_nettype none
module ddaq_csr (
   input  wire logic           clock,
   input  wire logic           reset,
   ddaq_csr_if.sink            csr_ch,
   output ddaq_pkg::ddaq_cfg_type cfg
);
   import ddaq_pkg::*;

   ddaq_cfg_type cfg_ff;
   ddaq_cfg_type cfg_in;
   logic         wr_en;

   assign csr_ch.ready = 1'b1;
   assign wr_en        = csr_ch.valid & csr_ch.ready;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_ch.index)
            CSR_ZERO_CUTOFF:      cfg_in.zero_cutoff      = csr_ch.data;
            CSR_BAND_ONE_LIMIT:   cfg_in.band_one_limit   = csr_ch.data;
            CSR_BAND_TWO_LIMIT:   cfg_in.band_two_limit   = csr_ch.data;
            CSR_BAND_THREE_LIMIT: cfg_in.band_three_limit = csr_ch.data;
            default:              cfg_in = cfg_ff;  // drop unknown index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_cutoff      <= RST_ZERO_CUTOFF;
         cfg_ff.band_one_limit   <= RST_BAND_ONE_LIMIT;
         cfg_ff.band_two_limit   <= RST_BAND_TWO_LIMIT;
         cfg_ff.band_three_limit <= RST_BAND_THREE_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/ddaq_conv.sv */
// Density conversion, display digits and band score of one ADC sample.
`default_nettype none
module ddaq_conv (
   input  wire logic [ddaq_pkg::SAMPLE_W-1:0] sample,
   input  ddaq_pkg::ddaq_cfg_type             cfg,
   output ddaq_pkg::ddaq_conv_type            conv
);
   import ddaq_pkg::*;

   localparam int SHIFT_W = PROD_W - ADC_BITS;
   localparam int TENS_W  = DENS_W + 8;

   logic [PROD_W-1:0]  scaled;
   logic [PROD_W-1:0]  offset;
   logic [PROD_W-1:0]  diff;
   logic [SHIFT_W-1:0] raw;
   logic [DENS_W-1:0]  dens;
   logic [TENS_W-1:0]  tens_prod;
   logic [DIGIT_W-1:0] tens;
   logic [DENS_W-1:0]  tens_x10;

   always_comb begin
      scaled = PROD_W'(DENS_SCALE) * PROD_W'(sample);
      offset = PROD_W'(DENS_OFFSET) << ADC_BITS;
      diff   = scaled - offset;
      raw    = diff[PROD_W-1:ADC_BITS];
      if (sample <= cfg.zero_cutoff || scaled <= offset) begin
         dens = '0;
      end else if (raw > SHIFT_W'(DENS_MAX)) begin
         dens = DENS_W'(DENS_MAX);
      end else begin
         dens = raw[DENS_W-1:0];
      end

      // divide by ten through the reciprocal 205/2048, exact below 1029
      tens_prod = TENS_W'(dens) * TENS_W'(205);
      tens      = DIGIT_W'(tens_prod >> 11);
      tens_x10  = DENS_W'(tens) * DENS_W'(10);

      conv.density    = dens;
      conv.tenths     = tens;
      conv.hundredths = DIGIT_W'(dens - tens_x10);

      if (sample <= cfg.band_one_limit) begin
         conv.score = SCORE_BAND_ZERO;
      end else if (sample <= cfg.band_two_limit) begin
         conv.score = SCORE_BAND_ONE;
      end else if (sample <= cfg.band_three_limit) begin
         conv.score = SCORE_BAND_TWO;
      end else begin
         conv.score = SCORE_BAND_THREE;
      end
   end
endmodule
`default_nettype wire

/* rtl/ddaq_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module ddaq_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  ddaq_pkg::ddaq_div_req_type        req,
   output ddaq_pkg::ddaq_div_stat_type       stat,
   output logic [ddaq_pkg::DIV_W-1:0]        quotient
);
   import ddaq_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DEN_W:0]       shifted;
   logic [DEN_W+1:0]     trial;
   logic                 fits;

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
      fits    = ~trial[DEN_W+1];
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the dust density air quality scorer top level.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ddaq_pkg::*;

   // Register indexes outside the map; writes to these must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LOW  = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HIGH = {CSR_IDX_W{1'b1}};

   localparam int RANDOM_PHASES    = 8;
   localparam int READINGS_PER_SET = 130;
   localparam int LONG_STALL       = 400;   // receiver hold-off, in cycles
   localparam int SETTLE_CYCLES    = 40;    // settle time; longest path is the divider
   localparam int STUCK_LIMIT      = 3000;  // cycles with no transaction at all

   typedef struct packed {
      logic                action;
      logic [SAMPLE_W-1:0] sample;
   } reading_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ddaq_req_if req_if ();
   ddaq_rsp_if rsp_if ();
   ddaq_csr_if csr_if ();

   dust_density_air_quality_scorer_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always #2 clock = ~clock;

   // Readings waiting to be offered, and scores the block still owes us
   reading_t     pending_readings[$];
   ddaq_res_type expected_scores[$];

   // Shadow of the block's configuration and run state
   ddaq_cfg_type           limits_m;
   logic [CNT_W-1:0]       sample_count_m;
   logic [SUM_W-1:0]       window_sum_m;
   logic [DIV_W-1:0]       run_total_m;
   logic [WCOUNT_W-1:0]    window_count_m;
   logic                   run_closed_m;

   int          fault_count = 0;
   int          stuck_cycles;
   logic        req_fire;
   int unsigned req_idle_pct;
   int unsigned rsp_idle_pct;
   int          stall_requests = 0;
   int          stall_served;
   int          stall_left;

   // Work out the score for one accepted transaction and queue it.
   // Nothing is owed once the finish event has closed the run.
   task automatic predict_scorer(input logic act, input logic [SAMPLE_W-1:0] adc);
      ddaq_res_type       r;
      int unsigned        scaled;
      int unsigned        dens;
      int unsigned        quot;
      logic [DIV_W-1:0]   avg;
      logic [SCORE_W-1:0] pts;
      if (run_closed_m) return;
      r = '0;
      if (act == ACT_FINISH) begin
         avg = run_total_m / (DIV_W'(window_count_m) + DIV_W'(1));
         r.is_final      = 1'b1;
         r.final_average = avg;
         if (avg == 0) r.final_class = CLASS_EXCELLENT;
         else if (avg <= FINAL_GOOD_LIMIT) r.final_class = CLASS_GOOD;
         else if (avg <= FINAL_POOR_LIMIT) r.final_class = CLASS_POOR;
         else r.final_class = CLASS_WORSE;
         run_total_m  = avg;
         run_closed_m = 1'b1;
      end else begin
         // Density: zero at or below the cutoff or when the line goes negative
         scaled = DENS_SCALE * adc;
         if (adc <= limits_m.zero_cutoff || scaled <= (DENS_OFFSET << ADC_BITS)) dens = 0;
         else dens = (scaled - (DENS_OFFSET << ADC_BITS)) >> ADC_BITS;
         if (dens > DENS_MAX) dens = DENS_MAX;
         r.density_hundredths = DENS_W'(dens);
         r.tenths_digit       = DIGIT_W'((dens / 10) % 10);
         r.hundredths_digit   = DIGIT_W'(dens % 10);

         if (adc <= limits_m.band_one_limit) pts = SCORE_BAND_ZERO;
         else if (adc <= limits_m.band_two_limit) pts = SCORE_BAND_ONE;
         else if (adc <= limits_m.band_three_limit) pts = SCORE_BAND_TWO;
         else pts = SCORE_BAND_THREE;
         window_sum_m   = window_sum_m + SUM_W'(pts);
         sample_count_m = CNT_W'((int'(sample_count_m) + 1) % WINDOW_WRAP);

         if (sample_count_m == CNT_W'(WINDOW_WRAP - 1)) begin
            quot = window_sum_m / (WINDOW_WRAP - 1);
            r.window_done  = 1'b1;
            r.window_class = (quot > 3) ? CLASS_WORSE : CLASS_W'(quot);
            run_total_m    = run_total_m + DIV_W'(quot);
            window_sum_m   = '0;
            window_count_m = window_count_m + WCOUNT_W'(1);
         end
      end
      expected_scores.push_back(r);
   endtask

   task automatic check_field(input string name, input logic [DIV_W-1:0] want,
                              input logic [DIV_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fault_count++;
      end
   endtask

   // Monitor: sample every channel at the rising edge, shadow config
   // writes, predict on accepted readings, check accepted scores, and run
   // the watchdog.
   always @(posedge clock) begin : monitor_scores
      ddaq_res_type want;
      if (reset) begin
         req_fire       <= 1'b0;
         stuck_cycles   <= 0;
         limits_m       = '{zero_cutoff:      RST_ZERO_CUTOFF,
                            band_one_limit:   RST_BAND_ONE_LIMIT,
                            band_two_limit:   RST_BAND_TWO_LIMIT,
                            band_three_limit: RST_BAND_THREE_LIMIT};
         sample_count_m = '0;
         window_sum_m   = '0;
         run_total_m    = '0;
         window_count_m = '0;
         run_closed_m   = 1'b0;
         expected_scores.delete();
      end else begin
         req_fire <= req_if.valid && req_if.ready;

         // Drop writes to indexes outside the register map
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_ZERO_CUTOFF:      limits_m.zero_cutoff      = csr_if.data;
               CSR_BAND_ONE_LIMIT:   limits_m.band_one_limit   = csr_if.data;
               CSR_BAND_TWO_LIMIT:   limits_m.band_two_limit   = csr_if.data;
               CSR_BAND_THREE_LIMIT: limits_m.band_three_limit = csr_if.data;
               default: ;
            endcase
         end

         if (req_if.valid && req_if.ready)
            predict_scorer(req_if.action, req_if.sample);

         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_scores.size() == 0) begin
               $error("score transaction arrived with nothing expected");
               fault_count++;
            end else begin
               want = expected_scores.pop_front();
               check_field("density_hundredths", want.density_hundredths,
                           rsp_if.density_hundredths);
               check_field("tenths_digit", want.tenths_digit, rsp_if.tenths_digit);
               check_field("hundredths_digit", want.hundredths_digit,
                           rsp_if.hundredths_digit);
               check_field("window_done", want.window_done, rsp_if.window_done);
               check_field("window_class", want.window_class, rsp_if.window_class);
               check_field("is_final", want.is_final, rsp_if.is_final);
               check_field("final_class", want.final_class, rsp_if.final_class);
               check_field("final_average", want.final_average, rsp_if.final_average);
            end
         end

         // Watchdog: count cycles in which no channel moves a transaction
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready)) begin
            stuck_cycles <= 0;
         end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("FAIL dust_density_air_quality_scorer_top");
            $finish;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
      end
   end

   // Driver: advance to the next reading only once the current one is taken,
   // idling at random in between.
   always @(negedge clock) begin : drive_readings
      reading_t nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fire) begin
         if (pending_readings.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            nxt = pending_readings.pop_front();
            req_if.valid  <= 1'b1;
            req_if.action <= nxt.action;
            req_if.sample <= nxt.sample;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure, plus a long hold-off on request so the
   // output and pending registers fill and the input stalls.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_served <= 0;
         stall_left   <= 0;
      end else if (stall_left != 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (stall_served != stall_requests) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= LONG_STALL;
         stall_served <= stall_served + 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic queue_reading(input logic act, input logic [SAMPLE_W-1:0] val);
      reading_t it;
      it.action = act;
      it.sample = val;
      pending_readings.push_back(it);
   endtask

   // Hold until every reading is taken and every score has come back.
   // Look just after the falling edge, once the driver's update has landed.
   task automatic wait_drained();
      do begin
         @(negedge clock);
         #1;
      end while (pending_readings.size() != 0 || req_if.valid ||
                 expected_scores.size() != 0);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic program_limits(input logic [REG_W-1:0] cut, input logic [REG_W-1:0] b1,
                                 input logic [REG_W-1:0] b2, input logic [REG_W-1:0] b3);
      write_csr(CSR_ZERO_CUTOFF, cut);
      write_csr(CSR_BAND_ONE_LIMIT, b1);
      write_csr(CSR_BAND_TWO_LIMIT, b2);
      write_csr(CSR_BAND_THREE_LIMIT, b3);
   endtask

   initial begin : stimulus
      logic [REG_W-1:0] lim [4];
      logic [REG_W-1:0] tmp;
      int unsigned      style;
      int unsigned      ceiling;
      int               val;

      // Known values on every input from time zero
      req_if.valid  = 1'b0;
      req_if.action = ACT_SAMPLE;
      req_if.sample = '0;
      csr_if.valid  = 1'b0;
      csr_if.index  = '0;
      csr_if.data   = '0;
      rsp_if.ready  = 1'b0;
      req_idle_pct  = 38;
      rsp_idle_pct  = 38;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes, alternating bits and band edges at reset limits
      queue_reading(ACT_SAMPLE, 10'd0);
      queue_reading(ACT_SAMPLE, 10'd1023);
      queue_reading(ACT_SAMPLE, 10'd120);
      queue_reading(ACT_SAMPLE, 10'd121);
      queue_reading(ACT_SAMPLE, 10'd168);
      queue_reading(ACT_SAMPLE, 10'd169);
      queue_reading(ACT_SAMPLE, 10'd216);
      queue_reading(ACT_SAMPLE, 10'd217);
      queue_reading(ACT_SAMPLE, 10'd313);
      queue_reading(ACT_SAMPLE, 10'd314);
      queue_reading(ACT_SAMPLE, 10'h155);
      queue_reading(ACT_SAMPLE, 10'h2AA);
      queue_reading(ACT_SAMPLE, 10'd512);
      queue_reading(ACT_SAMPLE, 10'd1);
      wait_drained();

      // All limits at zero: negative density line reads zero, all counts score ten.
      // Writes to unmapped indexes must leave the limits alone.
      program_limits('0, '0, '0, '0);
      write_csr(CSR_UNUSED_LOW, REG_W'($urandom));
      write_csr(CSR_UNUSED_HIGH, '1);
      queue_reading(ACT_SAMPLE, 10'd1);
      queue_reading(ACT_SAMPLE, 10'd2);
      queue_reading(ACT_SAMPLE, 10'd120);
      queue_reading(ACT_SAMPLE, 10'd1023);
      wait_drained();

      // All limits at the top: nothing reads density or scores
      program_limits('1, '1, '1, '1);
      queue_reading(ACT_SAMPLE, 10'd1023);
      queue_reading(ACT_SAMPLE, 10'd500);
      queue_reading(ACT_SAMPLE, 10'd0);
      wait_drained();

      // Random phases: new limits each time the block is drained
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         style = $urandom_range(3);
         case (style)
            0: begin
               lim[0] = RST_ZERO_CUTOFF;
               lim[1] = RST_BAND_ONE_LIMIT;
               lim[2] = RST_BAND_TWO_LIMIT;
               lim[3] = RST_BAND_THREE_LIMIT;
            end
            1: begin
               // ordered bands so every score shows up
               for (int k = 0; k < 4; k++) lim[k] = REG_W'($urandom_range(100, 500));
               if (lim[1] > lim[2]) begin tmp = lim[1]; lim[1] = lim[2]; lim[2] = tmp; end
               if (lim[2] > lim[3]) begin tmp = lim[2]; lim[2] = lim[3]; lim[3] = tmp; end
               if (lim[1] > lim[2]) begin tmp = lim[1]; lim[1] = lim[2]; lim[2] = tmp; end
            end
            2: begin
               for (int k = 0; k < 4; k++) lim[k] = ($urandom_range(1) != 0) ? '1 : '0;
            end
            default: begin
               for (int k = 0; k < 4; k++) lim[k] = REG_W'($urandom);
            end
         endcase
         program_limits(lim[0], lim[1], lim[2], lim[3]);

         // Spread the window quotients by capping the readings per phase
         case ($urandom_range(3))
            0:       ceiling = 1023;
            1:       ceiling = 320;
            2:       ceiling = 230;
            default: ceiling = 180;
         endcase

         // One phase runs with no idling on either side
         req_idle_pct = (phase == 5) ? 0 : 38;
         rsp_idle_pct = (phase == 5) ? 0 : 38;

         for (int k = 0; k < READINGS_PER_SET; k++) begin
            if ($urandom_range(99) < 25) begin
               val = int'(lim[$urandom_range(3)]) + int'($urandom_range(6)) - 3;
               if (val < 0) val = 0;
               if (val > 1023) val = 1023;
            end else begin
               val = int'($urandom_range(ceiling));
            end
            queue_reading(ACT_SAMPLE, SAMPLE_W'(val));
         end

         // Hold off the receiver while the sender keeps offering
         if (phase == 2) stall_requests = stall_requests + 1;
         wait_drained();
      end

      // Close the run; anything after the finish event must be dropped silently
      queue_reading(ACT_FINISH, SAMPLE_W'($urandom));
      queue_reading(ACT_SAMPLE, 10'd1023);
      queue_reading(ACT_FINISH, 10'd0);
      queue_reading(ACT_SAMPLE, 10'd0);
      wait_drained();

      // Give a stray late score time to show up
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fault_count == 0 && expected_scores.size() == 0) begin
         $display("PASS dust_density_air_quality_scorer_top");
      end else begin
         $display("FAIL dust_density_air_quality_scorer_top");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* sim.f */
rtl/ddaq_pkg.sv
rtl/ddaq_req_if.sv
rtl/ddaq_rsp_if.sv
rtl/ddaq_csr_if.sv
rtl/ddaq_csr.sv
rtl/ddaq_conv.sv
rtl/ddaq_div.sv
rtl/dust_density_air_quality_scorer_top.sv
tb/tb_top.sv
